FILE: rtl/shift_array_list_macros.svh
// assertion macros for the shift array list
`ifndef SHIFT_ARRAY_LIST_MACROS_SVH
`define SHIFT_ARRAY_LIST_MACROS_SVH

// same-cycle implication
`define SAL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SAL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/sal_pkg.sv
// package with shared types and constants of the shift array list
`default_nettype none

package sal_pkg;

	localparam int DATA_W       = 32;
	localparam int KIND_W       = 2;
	localparam int STAT_W       = 2;
	localparam int FILL_W       = 5;
	localparam int CAPACITY_DEF = 16;

	typedef enum logic [KIND_W-1:0] {
		K_APPEND  = 2'd0,
		K_PREPEND = 2'd1,
		K_DELETE  = 2'd2,
		K_DUMP    = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_SWEEP
	} state_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_APPEND,
		CELL_PREPEND,
		CELL_ROTATE,
		CELL_DROP
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [DATA_W-1:0]   value;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/sal_cell.sv
// one storage cell of the shift array list row
`default_nettype none

module sal_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  wire logic                        clk,
	input  wire sal_pkg::cell_ctrl_t         ctrl,
	input  wire logic [CNT_W-1:0]            tail,
	input  wire logic [sal_pkg::DATA_W-1:0]  left,
	input  wire logic [sal_pkg::DATA_W-1:0]  right,
	input  wire logic [sal_pkg::DATA_W-1:0]  wrap,
	output logic      [sal_pkg::DATA_W-1:0]  data
);

	logic [sal_pkg::DATA_W-1:0] data_q;
	logic                       at_tail;

	assign at_tail = (tail == CNT_W'(IDX));
	assign data    = data_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			sal_pkg::CELL_APPEND: begin
				if (at_tail) begin
					data_q <= ctrl.value;
				end
			end
			sal_pkg::CELL_PREPEND: begin
				data_q <= left;
			end
			sal_pkg::CELL_ROTATE: begin
				data_q <= at_tail ? wrap : right;
			end
			sal_pkg::CELL_DROP: begin
				data_q <= right;
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/shift_array_list.sv
// top level of the shift array list: control and the row of cells
//
// An item is taken when start is high and busy is low. Append and prepend
// finish in the cycle of the transfer; the row of cells shifts or loads in
// parallel and busy stays low, so a new item can follow in the next cycle.
// Delete and dump of a non-empty list rotate the whole row left through
// cell 0 once, one element a cycle, and hold busy while they sweep;
// delete drops the first match as it passes the head, dump emits each element
// as it passes. Every result appears on the outputs in the cycle after the step
// that makes it, for one cycle, marked by strobe; the receiver cannot stall,
// so it must take each result in that cycle. A dump of n elements gives n
// results in consecutive cycles. fill_count shows the low five bits of the
// element count.
`default_nettype none
`include "shift_array_list_macros.svh"

module shift_array_list #(
	parameter int CAPACITY = sal_pkg::CAPACITY_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [sal_pkg::KIND_W-1:0]         kind,
	input  wire logic signed [sal_pkg::DATA_W-1:0]  value,
	output logic                                    strobe,
	output logic signed [sal_pkg::DATA_W-1:0]       element,
	output logic [sal_pkg::STAT_W-1:0]              status,
	output logic [sal_pkg::FILL_W-1:0]              fill_count,
	output logic                                    last
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int DW    = sal_pkg::DATA_W;

	sal_pkg::state_t      state_q, state_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [CNT_W-1:0]     len_q, len_d;
	logic [CNT_W-1:0]     step_q, step_d;
	logic                 found_q, found_d;
	logic                 dump_q, dump_d;
	logic [DW-1:0]        key_q, key_d;

	logic                 strobe_q, strobe_d;
	logic [DW-1:0]        elem_q, elem_d;
	sal_pkg::status_t     status_q, status_d;
	logic [CNT_W-1:0]     fill_q, fill_d;
	logic                 last_q, last_d;

	sal_pkg::cell_ctrl_t  ctrl;
	logic [CNT_W-1:0]     tail;
	logic [DW-1:0]        cell_data [CAPACITY];
	logic [DW-1:0]        head;
	logic                 hit;
	logic                 last_step;
	logic                 full;

	assign head      = cell_data[0];
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign last_step = (step_q == count_q - CNT_W'(1));
	assign hit       = !dump_q && !found_q && (head == key_q);

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DW-1:0] left_d;
		logic [DW-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = value;
		end else begin : g_inner_l
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign right_d = head;
		end else begin : g_inner_r
			assign right_d = cell_data[i+1];
		end
		sal_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.tail  (tail),
			.left  (left_d),
			.right (right_d),
			.wrap  (head),
			.data  (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sal_pkg::S_IDLE;
			count_q  <= '0;
			len_q    <= '0;
			step_q   <= '0;
			found_q  <= 1'b0;
			dump_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			len_q    <= len_d;
			step_q   <= step_d;
			found_q  <= found_d;
			dump_q   <= dump_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q    <= key_d;
		elem_q   <= elem_d;
		status_q <= status_d;
		fill_q   <= fill_d;
		last_q   <= last_d;
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		len_d      = len_q;
		step_d     = step_q;
		found_d    = found_q;
		dump_d     = dump_q;
		key_d      = key_q;
		strobe_d   = 1'b0;
		elem_d     = '0;
		status_d   = sal_pkg::ST_OK;
		fill_d     = count_q;
		last_d     = 1'b1;
		ctrl.op    = sal_pkg::CELL_HOLD;
		ctrl.value = value;
		tail       = count_q;
		busy       = 1'b0;

		case (state_q)
			sal_pkg::S_IDLE: begin
				if (start) begin
					case (sal_pkg::kind_t'(kind))
						sal_pkg::K_APPEND, sal_pkg::K_PREPEND: begin
							strobe_d = 1'b1;
							if (full) begin
								status_d = sal_pkg::ST_FULL;
							end else begin
								ctrl.op = (sal_pkg::kind_t'(kind) == sal_pkg::K_APPEND) ?
									sal_pkg::CELL_APPEND : sal_pkg::CELL_PREPEND;
								count_d = count_q + CNT_W'(1);
								fill_d  = count_q + CNT_W'(1);
							end
						end
						sal_pkg::K_DELETE, sal_pkg::K_DUMP: begin
							if (count_q == '0) begin
								strobe_d = 1'b1;
								status_d = (sal_pkg::kind_t'(kind) == sal_pkg::K_DUMP) ?
									sal_pkg::ST_EMPTY : sal_pkg::ST_NOT_FOUND;
							end else begin
								state_d = sal_pkg::S_SWEEP;
								len_d   = count_q;
								step_d  = '0;
								found_d = 1'b0;
								dump_d  = (sal_pkg::kind_t'(kind) == sal_pkg::K_DUMP);
								key_d   = value;
							end
						end
						default: begin
							state_d = sal_pkg::S_IDLE;
						end
					endcase
				end
			end
			sal_pkg::S_SWEEP: begin
				busy    = 1'b1;
				tail    = len_q - CNT_W'(1);
				ctrl.op = hit ? sal_pkg::CELL_DROP : sal_pkg::CELL_ROTATE;
				len_d   = hit ? len_q - CNT_W'(1) : len_q;
				found_d = found_q || hit;
				step_d  = step_q + CNT_W'(1);
				if (dump_q) begin
					strobe_d = 1'b1;
					elem_d   = head;
					last_d   = last_step;
				end
				if (last_step) begin
					state_d = sal_pkg::S_IDLE;
					if (!dump_q) begin
						strobe_d = 1'b1;
						status_d = found_d ? sal_pkg::ST_OK : sal_pkg::ST_NOT_FOUND;
						count_d  = found_d ? count_q - CNT_W'(1) : count_q;
						fill_d   = found_d ? count_q - CNT_W'(1) : count_q;
					end
				end
			end
			default: begin
				state_d = sal_pkg::S_IDLE;
			end
		endcase
	end

	assign strobe     = strobe_q;
	assign element    = elem_q;
	assign status     = status_q;
	assign fill_count = sal_pkg::FILL_W'(fill_q);
	assign last       = last_q;

	`SAL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "count above capacity")
	`SAL_ASSERT_NEXT(a_append_grows,
		start && !busy && kind == sal_pkg::K_APPEND && !full,
		strobe && last && count_q == $past(count_q) + CNT_W'(1), "append did not grow list")
	`SAL_ASSERT_NOW(a_last_idle, strobe && last, !busy, "final result while still sweeping")
	`SAL_ASSERT_NOW(a_more_busy, strobe && !last, busy, "dump stream ended early")
	`SAL_ASSERT_NOW(a_empty_zero, strobe && status == sal_pkg::ST_EMPTY,
		fill_count == '0 && element == '0, "empty dump with data")

endmodule

`default_nettype wire

FILE: bench/shift_array_list_test.sv
// self-checking testbench for the shift array list with a scoreboard class
`timescale 1ns / 1ps

module shift_array_list_test;
	import sal_pkg::*;

	localparam int LIST_CAP    = CAPACITY_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int REPORT_MAX  = 10;
	localparam int RANDOM_ITEMS = 500;

	localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic signed [DATA_W-1:0] element;
		status_t                  status;
		logic [FILL_W-1:0]        fill;
		logic                     last;
	} list_result_t;

	class list_scoreboard;
		logic signed [DATA_W-1:0] stored[$];
		list_result_t             awaited[$];
		int                       mismatches;

		function new();
			mismatches = 0;
		endfunction

		function void push_result(logic signed [DATA_W-1:0] e, status_t s, logic l);
			list_result_t r;
			r.element = e;
			r.status  = s;
			r.fill    = FILL_W'(stored.size());
			r.last    = l;
			awaited.push_back(r);
		endfunction

		function void note_item(kind_t k, logic signed [DATA_W-1:0] v);
			int hit;
			hit = -1;
			case (k)
				K_APPEND, K_PREPEND: begin
					if (stored.size() >= LIST_CAP) begin
						push_result('0, ST_FULL, 1'b1);
					end else begin
						if (k == K_APPEND)
							stored.push_back(v);
						else
							stored.push_front(v);
						push_result('0, ST_OK, 1'b1);
					end
				end
				K_DELETE: begin
					for (int i = 0; i < stored.size(); i++) begin
						if (hit < 0 && stored[i] == v)
							hit = i;
					end
					if (hit < 0) begin
						push_result('0, ST_NOT_FOUND, 1'b1);
					end else begin
						stored.delete(hit);
						push_result('0, ST_OK, 1'b1);
					end
				end
				default: begin
					if (stored.size() == 0)
						push_result('0, ST_EMPTY, 1'b1);
					else
						for (int i = 0; i < stored.size(); i++)
							push_result(stored[i], ST_OK, i == stored.size() - 1);
				end
			endcase
		endfunction

		function void check_result(logic signed [DATA_W-1:0] e, logic [STAT_W-1:0] s,
				logic [FILL_W-1:0] f, logic l);
			list_result_t x;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result: element %0d status %0d fill %0d last %0d",
						e, s, f, l);
				return;
			end
			x = awaited.pop_front();
			if (x.element !== e || x.status !== s || x.fill !== f || x.last !== l) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("mismatch at %0t: element %0d/%0d status %0d/%0d",
						$realtime, x.element, e, x.status, s);
					$display("  fill %0d/%0d last %0d/%0d (expected/actual)",
						x.fill, f, x.last, l);
				end
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [KIND_W-1:0]        kind;
	logic signed [DATA_W-1:0] value;
	logic                     strobe;
	logic signed [DATA_W-1:0] element;
	logic [STAT_W-1:0]        status;
	logic [FILL_W-1:0]        fill_count;
	logic                     last;

	list_scoreboard sb;
	bit             steady;
	int             quiet_cycles;

	shift_array_list #(
		.CAPACITY(LIST_CAP)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.value     (value),
		.strobe    (strobe),
		.element   (element),
		.status    (status),
		.fill_count(fill_count),
		.last      (last)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result(element, status, fill_count, last);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("shift_array_list regression: fail");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1, 2, 3: return $signed(32'($urandom_range(0, 7))) - 4;
			4: begin
				case ($urandom_range(0, 3))
					0: return INT_MIN;
					1: return INT_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// hold start until the transfer, then optionally idle
	task automatic issue(input kind_t k, input logic signed [DATA_W-1:0] v);
		int gap;
		@(negedge clk);
		start = 1'b1;
		kind  = k;
		value = v;
		do @(posedge clk); while (busy);
		sb.note_item(k, v);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			kind  = kind_t'($urandom_range(0, 3));
			value = $urandom;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic random_item(input bit growing);
		int    r;
		kind_t k;
		logic signed [DATA_W-1:0] v;
		r = $urandom_range(0, 99);
		if (growing)
			k = r < 45 ? K_APPEND : r < 80 ? K_PREPEND : r < 90 ? K_DELETE : K_DUMP;
		else
			k = r < 15 ? K_APPEND : r < 25 ? K_PREPEND : r < 85 ? K_DELETE : K_DUMP;
		v = pick_value();
		if (k == K_DELETE && sb.stored.size() != 0 && $urandom_range(0, 3) != 0)
			v = sb.stored[$urandom_range(0, sb.stored.size() - 1)];
		issue(k, v);
	endtask

	initial begin
		bit growing;
		sb     = new();
		arst_n = 1'b0;
		start  = 1'b0;
		kind   = K_APPEND;
		value  = '0;
		steady = 1'b0;
		growing = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty list cases, then four items added and dumped
		issue(K_DUMP, 32'sd0);
		issue(K_DELETE, 32'sd5);
		issue(K_APPEND, INT_MIN);
		issue(K_PREPEND, INT_MAX);
		issue(K_APPEND, 32'sd0);
		issue(K_APPEND, -32'sd1);
		issue(K_DUMP, INT_MAX);
		// delete at the tail, at the head, and a miss
		issue(K_DELETE, -32'sd1);
		issue(K_DELETE, INT_MAX);
		issue(K_DELETE, 32'sd12345);
		for (int i = 0; i < LIST_CAP - 2; i++)
			issue(i % 2 ? K_PREPEND : K_APPEND, i % 3 == 0 ? 32'sd7 : pick_value());
		// refusals on a full list, then a dump and a delete on it
		issue(K_APPEND, 32'sd99);
		issue(K_PREPEND, 32'sd99);
		issue(K_DUMP, '1);
		issue(K_DELETE, 32'sd7);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				steady = ($urandom_range(0, 3) == 0);
			if (sb.stored.size() >= LIST_CAP && $urandom_range(0, 3) == 0)
				growing = 1'b0;
			else if (sb.stored.size() == 0)
				growing = 1'b1;
			else if ($urandom_range(0, 29) == 0)
				growing = !growing;
			random_item(growing);
		end

		@(negedge clk);
		start = 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("shift_array_list regression: pass");
		else
			$display("shift_array_list regression: fail");
		$finish;
	end

endmodule

FILE: shift_array_list.f
+incdir+rtl
rtl/sal_pkg.sv
rtl/sal_cell.sv
rtl/shift_array_list.sv
bench/shift_array_list_test.sv
